### hdl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_TAB,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } tcw_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR
    } tcw_state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tcw_req_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } tcw_res_t;

    typedef struct packed {
        tcw_op_t     op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tcw_job_t;

endpackage

### hdl/text_console_writer.sv
// Top level of the text console writer: register port, front end, back end, result queue.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   request   | push / full          | req_data: cmd, char_code, cell_index
//   result    | pop / empty          | res_data: cursor_pos, cell_char, cell_attr, scrolled
//   register  | psel/penable/pwrite  | paddr, pwdata, prdata; text_attr at byte 0
//
// Put and unused commands end in ST_SETTLE and reads in ST_READ; a tab, or a print that
// passes a row end, stays in ST_SETTLE while each column wrap folds into the row. ST_SCROLL
// copies rows up, ST_FILL zeroes the last row and ST_CLEAR writes every cell, all through the
// single write port of the cell store. Reset homes the cursor and sets the attribute to
// 0x0F; cell contents stay unknown until written, so clear the screen first. Two-entry
// queues on both sides let requests and results stall independently of the back end.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  tcw_req_t    req_data,
    output logic        empty,
    input  logic        pop,
    output tcw_res_t    res_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] text_attr_reg;
    logic [7:0] text_attr_next;
    logic       reg_write;
    logic       job_avail;
    logic       job_take;
    tcw_job_t   job;
    logic       res_full;
    logic       res_push;
    tcw_res_t   res_item;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTR);
    assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? {24'h000000, text_attr_reg} : '0;

    always_comb
    begin
        text_attr_next = text_attr_reg;
        if (reg_write)
        begin
            text_attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= DEFAULT_ATTR;
        end
        else
        begin
            text_attr_reg <= text_attr_next;
        end
    end

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req_item  (req_data),
        .full      (full),
        .job_avail (job_avail),
        .job_take  (job_take),
        .job       (job)
    );

    tcw_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_attr (text_attr_reg),
        .job_avail (job_avail),
        .job_take  (job_take),
        .job       (job),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    tcw_fifo #(
        .item_t (tcw_res_t)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_item (res_item),
        .full    (res_full),
        .pop     (pop),
        .rd_item (res_data),
        .empty   (empty)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_avail)
        else $error("job taken from an empty queue");

    a_one_job_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> !job_take)
        else $error("back end took two jobs in a row");

    a_scroll_has_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_item.scrolled) |-> (res_item.cell_char == 8'h00 &&
                                             res_item.cell_attr == 8'h00))
        else $error("scrolled result carries cell data");

endmodule

### hdl/tcw_fifo.sv
// Small first-in first-out queue of packed items.
module tcw_fifo
    import tcw_pkg::*;
#(
    parameter type item_t = logic [7:0]
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output item_t rd_item,
    output logic  empty
);

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNTW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hdl/tcw_front.sv
// Front end: accepts requests, classifies them and queues jobs for the back end.
module tcw_front
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tcw_req_t req_item,
    output logic     full,
    output logic     job_avail,
    input  logic     job_take,
    output tcw_job_t job
);

    tcw_job_t job_in;
    logic     job_empty;

    always_comb
    begin
        job_in.char_code  = req_item.char_code;
        job_in.cell_index = req_item.cell_index;
        case (req_item.cmd)
            CMD_PUT:
            begin
                case (req_item.char_code)
                    CH_NEWLINE:   job_in.op = OP_NEWLINE;
                    CH_TAB:       job_in.op = OP_TAB;
                    CH_BACKSPACE: job_in.op = OP_BACKSPACE;
                    default:      job_in.op = OP_PRINT;
                endcase
            end
            CMD_CLEAR: job_in.op = OP_CLEAR;
            CMD_READ:  job_in.op = OP_READ;
            default:   job_in.op = OP_NONE;
        endcase
    end

    tcw_fifo #(
        .item_t (tcw_job_t)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (job_in),
        .full    (full),
        .pop     (job_take),
        .rd_item (job),
        .empty   (job_empty)
    );

    assign job_avail = !job_empty;

endmodule

### hdl/tcw_back.sv
// Back end: cell store, cursor and the sequencer that carries out each job.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] text_attr,
    input  logic       job_avail,
    output logic       job_take,
    input  tcw_job_t   job,
    input  logic       res_full,
    output logic       res_push,
    output tcw_res_t   res_item
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + COLS + TAB_STEP + 1);
    localparam int CW    = $clog2(COLS + TAB_STEP + 1);

    localparam logic [PW-1:0] COLS_P  = PW'(COLS);
    localparam logic [PW-1:0] CELLS_P = PW'(CELLS);
    localparam logic [PW-1:0] TAB_P   = PW'(TAB_STEP);
    localparam logic [CW-1:0] COLS_C  = CW'(COLS);
    localparam logic [CW-1:0] TAB_C   = CW'(TAB_STEP);

    logic [15:0]    mem [CELLS];
    logic [15:0]    rd_data_reg;

    tcw_state_t     state_reg;
    tcw_state_t     state_next;
    logic [PW-1:0]  pos_reg;
    logic [PW-1:0]  pos_next;
    logic [PW-1:0]  row_reg;
    logic [PW-1:0]  row_next;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [PW-1:0]  cnt_reg;
    logic [PW-1:0]  cnt_next;
    logic           rd_ok_reg;
    logic           rd_ok_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [15:0]    wdata;
    logic           re;
    logic [AW-1:0]  raddr;
    logic [7:0]     attr;
    logic [PW-1:0]  scroll_dst;
    logic [PW-1:0]  pos_up;

    assign attr       = (text_attr == '0) ? DEFAULT_ATTR : text_attr;
    assign scroll_dst = cnt_reg - COLS_P - PW'(1);
    assign pos_up     = pos_reg - COLS_P;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        rd_ok_next = rd_ok_reg;
        job_take   = 1'b0;
        res_push   = 1'b0;
        res_item   = '{cursor_pos: 11'(pos_reg), cell_char: 8'h00,
                       cell_attr: 8'h00, scrolled: 1'b0};
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = {attr, job.char_code};
        re         = 1'b0;
        raddr      = AW'(job.cell_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (job_avail && !res_full)
                begin
                    job_take   = 1'b1;
                    state_next = ST_SETTLE;
                    case (job.op)
                        OP_PRINT:
                        begin
                            we       = 1'b1;
                            pos_next = pos_reg + PW'(1);
                            col_next = col_reg + CW'(1);
                        end
                        OP_BACKSPACE:
                        begin
                            we    = 1'b1;
                            wdata = {attr, CH_SPACE};
                        end
                        OP_NEWLINE:
                        begin
                            row_next = row_reg + COLS_P;
                            pos_next = row_reg + COLS_P;
                            col_next = '0;
                        end
                        OP_TAB:
                        begin
                            pos_next = pos_reg + TAB_P;
                            col_next = col_reg + TAB_C;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            re         = 1'b1;
                            rd_ok_next = (32'(job.cell_index) < 32'(CELLS));
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SETTLE:
            begin
                if (col_reg >= COLS_C)
                begin
                    col_next = col_reg - COLS_C;
                    row_next = row_reg + COLS_P;
                end
                else if (pos_reg >= CELLS_P)
                begin
                    if (pos_up >= CELLS_P)
                    begin
                        pos_next = CELLS_P - PW'(1);
                        row_next = CELLS_P - COLS_P;
                        col_next = COLS_C - CW'(1);
                    end
                    else
                    begin
                        pos_next = pos_up;
                        row_next = row_reg - COLS_P;
                    end
                    cnt_next   = COLS_P;
                    state_next = ST_SCROLL;
                end
                else
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_READ:
            begin
                if (rd_ok_reg)
                begin
                    res_item.cell_char = rd_data_reg[7:0];
                    res_item.cell_attr = rd_data_reg[15:8];
                end
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCROLL:
            begin
                // read one row ahead, write the word fetched last cycle
                if (cnt_reg < CELLS_P)
                begin
                    re    = 1'b1;
                    raddr = cnt_reg[AW-1:0];
                end
                if (cnt_reg != COLS_P)
                begin
                    we    = 1'b1;
                    waddr = scroll_dst[AW-1:0];
                    wdata = rd_data_reg;
                end
                if (cnt_reg == CELLS_P)
                begin
                    cnt_next   = CELLS_P - COLS_P;
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + PW'(1);
                end
            end

            ST_FILL:
            begin
                we    = 1'b1;
                waddr = cnt_reg[AW-1:0];
                wdata = '0;
                if (cnt_reg == CELLS_P - PW'(1))
                begin
                    res_item.scrolled = 1'b1;
                    res_push          = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + PW'(1);
                end
            end

            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[AW-1:0];
                wdata = {DEFAULT_ATTR, CH_SPACE};
                if (cnt_reg == CELLS_P - PW'(1))
                begin
                    pos_next            = '0;
                    row_next            = '0;
                    col_next            = '0;
                    res_item.cursor_pos = '0;
                    res_push            = 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + PW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

endmodule
